// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checks in the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every rising edge outside reset.
`define B64E_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define B64E_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

// ===== hw/rtl/b64e_pkg.sv =====
// Package with the job type, group position codes and symbol alphabet of the encoder.
package b64e_pkg;

  // Position of the next byte within its three-byte group, one-hot.
  typedef enum logic [2:0] {
    POS_FIRST  = 3'b001,
    POS_SECOND = 3'b010,
    POS_THIRD  = 3'b100
  } b64e_pos_t;

  // One classified byte: the one or two 6-bit symbols it produces.
  typedef struct packed {
    logic [5:0] sym0;
    logic [5:0] sym1;
    logic       two;
    logic       last;
  } b64e_job_t;

  // Front-end state, visible for checks.
  typedef struct packed {
    b64e_pos_t  pos;
    logic [3:0] carry;
  } b64e_front_stat_t;

  // Queue handshake toward the front end.
  typedef struct packed {
    logic       push;
    b64e_job_t  job;
  } b64e_push_t;

  // Queue status toward the back end.
  typedef struct packed {
    logic       avail;
    b64e_job_t  job;
  } b64e_head_t;

  // Maps a 6-bit symbol to its base64url ASCII code.
  function automatic logic [6:0] sym_to_ascii(input logic [5:0] sym);
    logic [6:0] s;
    logic [6:0] code;
    s = {1'b0, sym};
    if (sym < 6'd26) begin
      code = s + 7'd65;
    end else if (sym < 6'd52) begin
      code = s + 7'd71;
    end else if (sym < 6'd62) begin
      code = s - 7'd4;
    end else if (sym == 6'd62) begin
      code = 7'd45;
    end else begin
      code = 7'd95;
    end
    return code;
  endfunction

endpackage

// ===== hw/rtl/b64e_if.sv =====
// Stream interfaces for raw input bytes and output characters.
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

// ===== hw/rtl/b64e_front.sv =====
// Front end: accepts bytes, tracks the group position and splits bits into symbols.
module b64e_front import b64e_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  logic             q_full,
  output b64e_push_t       push,
  output b64e_front_stat_t stat
);

  b64e_pos_t  pos_r;
  b64e_pos_t  pos_nxt;
  logic [3:0] carry_r;
  logic [3:0] carry_nxt;
  b64e_job_t  job;
  logic       take;

  // A word is taken whenever the queue has room.
  assign in_ready = !q_full;
  assign take     = in_valid && !q_full;

  // Split the byte against the leftover bits of the previous one.
  // Any code other than the second or third position is handled as the first.
  always_comb begin
    job.last = in_last;
    unique case (pos_r)
      POS_SECOND: begin
        job.sym0  = {carry_r[1:0], in_byte[7:4]};
        job.sym1  = {in_byte[3:0], 2'b00};
        job.two   = in_last;
        pos_nxt   = POS_THIRD;
        carry_nxt = in_byte[3:0];
      end
      POS_THIRD: begin
        job.sym0  = {carry_r[3:0], in_byte[7:6]};
        job.sym1  = in_byte[5:0];
        job.two   = 1'b1;
        pos_nxt   = POS_FIRST;
        carry_nxt = 4'd0;
      end
      default: begin
        job.sym0  = in_byte[7:2];
        job.sym1  = {in_byte[1:0], 4'b0000};
        job.two   = in_last;
        pos_nxt   = POS_SECOND;
        carry_nxt = {2'b00, in_byte[1:0]};
      end
    endcase
    // The end of a message starts a fresh group.
    if (in_last) begin
      pos_nxt   = POS_FIRST;
      carry_nxt = 4'd0;
    end
  end

  // Group state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_FIRST;
      carry_r <= 4'd0;
    end else if (take) begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign push.push = take;
  assign push.job  = job;
  assign stat.pos   = pos_r;
  assign stat.carry = carry_r;

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// Short job queue between the front end and the character back end.
module b64e_queue import b64e_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  b64e_push_t push,
  output logic       full,
  input  logic       pop,
  output b64e_head_t head,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_job_t     slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push.push && !full;
  assign do_pop  = pop && (count_r != '0);

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head.avail = (count_r != '0);
  assign head.job   = slot_r[rd_ptr_r];
  assign level      = count_r;

endmodule

// ===== hw/rtl/b64e_back.sv =====
// Back end: emits one character per cycle while jobs are queued and the receiver is ready, through an output register.
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  b64e_head_t head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last,
  output logic       pend_valid
);

  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       out_last_r;
  logic       pend_valid_r;
  logic [5:0] pend_sym_r;
  logic       pend_last_r;
  logic       load;

  // The output register takes a new character when empty or being drained.
  assign load = !out_valid_r || out_ready;
  assign pop  = load && !pend_valid_r && head.avail;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (load) begin
      if (pend_valid_r) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= head.avail;
        pend_valid_r <= head.avail && head.job.two;
      end
    end
  end

  // Payload registers: the pending second symbol goes first, then a new job.
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid_r) begin
        out_char_r <= sym_to_ascii(pend_sym_r);
        out_last_r <= pend_last_r;
      end else begin
        out_char_r  <= sym_to_ascii(head.job.sym0);
        out_last_r  <= head.job.last && !head.job.two;
        pend_sym_r  <= head.job.sym1;
        pend_last_r <= head.job.last;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;
  assign pend_valid = pend_valid_r;

endmodule

// ===== hw/rtl/base64url_stream_encoder.sv =====
// Top level of the base64url stream encoder.
// Encodes one raw byte per input word into base64url ASCII characters (A-Z, a-z, 0-9, '-',
// '_') with no padding; in_last closes a message, flushes any partial group with zero fill
// and marks the final character with out_last. The output delivers one character per
// cycle while the receiver is ready; over a long message it carries four characters
// per three bytes, and the single-character output register limits the byte intake rate.
// When nothing stalls, the first character of a byte passes the queue slot and then
// the output register before it is presented on the output. A queue of FIFO_DEPTH
// classified bytes separates the input from the output, so input ready depends only on
// that queue having room.
`include "assert_macros.svh"

module base64url_stream_encoder import b64e_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  b64e_byte_if.sink    in_ch,
  b64e_char_if.source  out_ch
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  b64e_push_t       push;
  b64e_head_t       head;
  b64e_front_stat_t fstat;
  logic             q_full;
  logic             pop;
  logic             pend_valid;
  logic [CW-1:0]    q_level;
  logic             grp_clean;
  logic             last_shown;

  // Front end: byte intake and bit splitting.
  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.in_byte),
    .in_last  (in_ch.in_last),
    .q_full   (q_full),
    .push     (push),
    .stat     (fstat)
  );

  // Job queue.
  b64e_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head),
    .level (q_level)
  );

  // Back end: character output.
  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_char   (out_ch.out_char),
    .out_last   (out_ch.out_last),
    .pend_valid (pend_valid)
  );

  // Conditions used by the checks below.
  assign grp_clean  = (fstat.pos == POS_FIRST) && (fstat.carry == 4'd0);
  assign last_shown = out_ch.valid && out_ch.out_last;

  // The queue never holds more jobs than it has slots.
  `B64E_ASSERT_ALWAYS(a_queue_bound, q_level <= CW'(FIFO_DEPTH), "queue overfilled")

  // The front end never pushes into a full queue.
  `B64E_ASSERT_ALWAYS(a_no_push_full, !(push.push && q_full), "push into full queue")

  // After the last byte of a message the group restarts clean.
  `B64E_ASSERT_NEXT(a_last_resets, push.push && push.job.last, grp_clean, "group not reset")

  // A final character is never followed by a pending second symbol.
  `B64E_ASSERT_ALWAYS(a_last_no_pend, !(last_shown && pend_valid), "pending after final one")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the base64url stream encoder: directed and random messages against a predictor.
module tb import b64e_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 16;
  localparam int RANDOM_BYTES   = 820;

  // Base64url alphabet; entry 0 is the leftmost character.
  localparam logic [0:63][7:0] URL_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  // Receiver ready patterns.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  // One expected output character.
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } url_char_t;

  logic clk = 1'b0;
  logic rst_n;

  b64e_byte_if byte_ch ();
  b64e_char_if char_ch ();

  base64url_stream_encoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (byte_ch),
    .out_ch (char_ch)
  );

  // Predictor state and the characters it still expects.
  b64e_pos_t  grp_pos;
  logic [3:0] grp_carry;
  url_char_t  pending_chars[$];

  int       errors;
  int       burst_left;
  int       stall_cycles;
  rx_mode_t rx_mode;
  int       rx_phase;

  always #5 clk = ~clk;

  // Queues one character for a 6-bit symbol.
  function automatic void push_char(input logic [5:0] sym, input logic last);
    url_char_t c;
    c.code = URL_ALPHABET[sym][6:0];
    c.last = last;
    pending_chars = {pending_chars, c};
  endfunction

  // Advances the group state by one accepted byte and queues the characters it yields.
  function automatic void encode_byte(input logic [7:0] b, input logic last);
    case (grp_pos)
      POS_SECOND: begin
        push_char({grp_carry[1:0], b[7:4]}, 1'b0);
        grp_carry = b[3:0];
        if (last) begin
          push_char({grp_carry, 2'b00}, 1'b1);
        end
        grp_pos = POS_THIRD;
      end
      POS_THIRD: begin
        push_char({grp_carry, b[7:6]}, 1'b0);
        push_char(b[5:0], last);
        grp_carry = 4'h0;
        grp_pos = POS_FIRST;
      end
      default: begin
        push_char(b[7:2], 1'b0);
        grp_carry = {2'b00, b[1:0]};
        if (last) begin
          push_char({b[1:0], 4'b0000}, 1'b1);
        end
        grp_pos = POS_SECOND;
      end
    endcase
    // A closed message starts the next one at a fresh group.
    if (last) begin
      grp_pos = POS_FIRST;
      grp_carry = 4'h0;
    end
  endfunction

  // Sends one word, opening a new burst after a random gap when the current one is used up.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
      byte_ch.valid <= 1'b0;
      byte_ch.in_byte <= 8'($urandom);
      byte_ch.in_last <= 1'($urandom);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    byte_ch.valid <= 1'b1;
    byte_ch.in_byte <= b;
    byte_ch.in_last <= last;
    do @(posedge clk); while (!byte_ch.ready);
    encode_byte(b, last);
  endtask

  // Sends a short message packed with its first byte in the most significant position.
  task automatic send_packed(input logic [47:0] bytes, input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(bytes[8 * (len - 1 - i) +: 8], i == len - 1);
    end
  endtask

  // Holds the input idle until every expected character has come out.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
    burst_left = 0;
  endtask

  // Messages of one to five bytes with extreme values and both special symbols.
  task automatic test_directed_messages();
    send_packed(48'h00, 1);
    send_packed(48'hFF, 1);
    send_packed(48'hFFFF, 2);
    send_packed(48'hFBFFBF, 3);
    send_packed(48'h000000, 3);
    send_packed(48'h8001FF7F, 4);
    send_packed(48'h55AA0F3CF0, 5);
  endtask

  // The input pauses until the output is empty, once in each group position.
  task automatic test_pause_mid_message();
    send_byte(8'hA5, 1'b0);
    wait_drained();
    send_byte(8'h5A, 1'b0);
    wait_drained();
    send_byte(8'hC3, 1'b0);
    wait_drained();
    send_byte(8'h3C, 1'b1);
    wait_drained();
  endtask

  // Random messages, mostly short, with a drain pause now and then at a random spot.
  task automatic test_random_messages(input int n_bytes);
    int sent;
    int len;
    int until_pause;
    logic [7:0] b;
    sent = 0;
    until_pause = $urandom_range(80, 200);
    while (sent < n_bytes) begin
      case ($urandom_range(0, 19)) inside
        0:       len = $urandom_range(25, 64);
        [1:5]:   len = $urandom_range(7, 24);
        default: len = $urandom_range(1, 6);
      endcase
      for (int i = 0; i < len; i++) begin
        // Bias some bytes toward all-zero and all-one patterns.
        case ($urandom_range(0, 15))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom);
        endcase
        send_byte(b, i == len - 1);
        sent++;
        until_pause--;
        if (until_pause == 0) begin
          wait_drained();
          until_pause = $urandom_range(80, 200);
        end
      end
    end
  endtask

  // Receiver ready follows a pattern that switches mode at random intervals.
  always @(posedge clk) begin
    if (rx_phase == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_phase <= $urandom_range(16, 96);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      RX_OPEN:     char_ch.ready <= 1'b1;
      RX_COIN:     char_ch.ready <= 1'($urandom);
      RX_SPARSE:   char_ch.ready <= ($urandom_range(0, 7) != 0);
      default:     char_ch.ready <= rx_phase[3];
    endcase
  end

  // Compares each accepted character with the oldest expected one.
  always @(posedge clk) begin
    url_char_t want;
    if (rst_n && char_ch.valid && char_ch.ready) begin
      if (pending_chars.size() == 0) begin
        errors++;
        $error("unexpected character: out_char %0d out_last %0d",
               char_ch.out_char, char_ch.out_last);
      end else begin
        want = pending_chars.pop_front();
        if (char_ch.out_char !== want.code) begin
          errors++;
          $error("out_char: expected %0d, got %0d", want.code, char_ch.out_char);
        end
        if (char_ch.out_last !== want.last) begin
          errors++;
          $error("out_last: expected %0d, got %0d", want.last, char_ch.out_last);
        end
      end
    end
  end

  // Ends the run when neither side moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL base64url_stream_encoder");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.in_byte = 8'h00;
    byte_ch.in_last = 1'b0;
    char_ch.ready = 1'b0;
    rx_mode = RX_OPEN;
    rx_phase = 0;
    stall_cycles = 0;
    errors = 0;
    burst_left = 0;
    grp_pos = POS_FIRST;
    grp_carry = 4'h0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_messages();
    test_pause_mid_message();
    test_random_messages(RANDOM_BYTES);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_chars.size() == 0) begin
      $display("PASS base64url_stream_encoder");
    end else begin
      $display("FAIL base64url_stream_encoder");
    end
    $finish;
  end

endmodule
